// File: sv/s2dww_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the separable 2-D window weighting block.
// Depends on nothing; the controller, datapath and top level import it.

package s2dww_pkg;

   // Default sizes, handed down as module parameters from the top level
   localparam int unsigned DEF_MAX_DIM        = 1024;
   localparam int unsigned DEF_SAMPLE_BITS    = 16;
   localparam int unsigned DEF_PHASE_BITS     = 16;
   localparam int unsigned DEF_COS_TABLE_BITS = 10;

   // Register port widths
   localparam int unsigned COUNT_BITS    = 11;
   localparam int unsigned STEP_BITS     = 16;
   localparam int unsigned CSR_DATA_BITS = 16;
   localparam int unsigned CSR_IDX_BITS  = 2;

   // Register reset values
   localparam logic [COUNT_BITS-1:0] RST_ROW_COUNT    = 11'd32;
   localparam logic [COUNT_BITS-1:0] RST_COLUMN_COUNT = 11'd32;
   localparam logic [STEP_BITS-1:0]  RST_ROW_STEP     = 16'd2114;
   localparam logic [STEP_BITS-1:0]  RST_COLUMN_STEP  = 16'd2114;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROW_COUNT         = 2'd0,
      CSR_COLUMN_COUNT      = 2'd1,
      CSR_ROW_PHASE_STEP    = 2'd2,
      CSR_COLUMN_PHASE_STEP = 2'd3
   } csr_index_type;

   // Hamming weight in Q1.15: w = (alpha*32768 + 16384 - beta*c) >> 15.
   // The bias holds 17809*32768 plus the rounding half.
   localparam logic signed [31:0] WEIGHT_BIAS = 32'sd583581696;
   localparam logic signed [31:0] BETA_Q15    = 32'sd14959;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic sample_ld;  // capture the accepted word
      logic rom_rd;     // read the cosine ROM
      logic rom_col;    // address the ROM from the column phase
      logic wr_ld;      // register the row weight
      logic wc_ld;      // register the column weight
      logic ww_ld;      // register the product of the two weights
      logic prod_ld;    // register sample times combined weight
      logic commit;     // load the output word and step the counters
   } ctrl_cmd_type;

endpackage

// File: sv/s2dww_cos_rom.sv
`timescale 1ns / 1ps
// Quarter-wave cosine ROM, Q15 entries built at elaboration time.
// Depends on nothing outside this file.

module s2dww_cos_rom #(
   parameter int unsigned COS_TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [COS_TABLE_BITS:0]   rd_addr,
   output logic [15:0]               rd_data
);

   localparam int unsigned DEPTH = (1 << COS_TABLE_BITS) + 1;
   localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30    = 64'd1073741824;

   typedef logic [15:0] rom_type [0:DEPTH-1];

   // Quotient of the series terms by shift and subtract.
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // One entry: cos(pi/2 * t / 2^bits) by an eleven-term Taylor series in Q30
   function automatic logic [15:0] cos_entry(input int unsigned t);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      longint unsigned r;
      longint unsigned den;
      x   = (PIHALF_Q30 * longint'(t)) >> COS_TABLE_BITS;
      x2  = (x * x) >> 30;
      mag = ONE_Q30;
      sum = longint'(ONE_Q30);
      for (int k = 1; k <= 10; k++) begin
         den = 64'(unsigned'((2 * k - 1) * (2 * k)));
         mag = udiv((mag * x2) >> 30, den);
         if ((k % 2) == 1) begin
            sum = sum - longint'(mag);
         end else begin
            sum = sum + longint'(mag);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (longint'(sum) + 64'd16384) >> 15;
      return r[15:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int unsigned t = 0; t < DEPTH; t++) begin
         r[t] = cos_entry(t);
      end
      return r;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic [15:0] rd_data_ff;

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= COS_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/s2dww_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: accepts a word, steps the datapath through the
// lookups and multiplies, and owns the output valid. Uses s2dww_pkg.

module s2dww_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output s2dww_pkg::ctrl_cmd_type  cmd
);

   import s2dww_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_WT,
      ST_COL_RD,
      ST_COL_WT,
      ST_MUL_WW,
      ST_MUL_S,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Command decode and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.sample_ld = 1'b1;
               state_in      = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            cmd.rom_rd = 1'b1;
            state_in   = ST_ROW_WT;
         end
         ST_ROW_WT: begin
            cmd.wr_ld = 1'b1;
            state_in  = ST_COL_RD;
         end
         ST_COL_RD: begin
            cmd.rom_rd  = 1'b1;
            cmd.rom_col = 1'b1;
            state_in    = ST_COL_WT;
         end
         ST_COL_WT: begin
            cmd.wc_ld = 1'b1;
            state_in  = ST_MUL_WW;
         end
         ST_MUL_WW: begin
            cmd.ww_ld = 1'b1;
            state_in  = ST_MUL_S;
         end
         ST_MUL_S: begin
            cmd.prod_ld = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Wait here only while the previous word is still held
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/s2dww_dp.sv
`timescale 1ns / 1ps
// Datapath: registers, raster counters, phase accumulators, weight
// arithmetic and the output word. Uses s2dww_pkg and s2dww_cos_rom.

module s2dww_dp #(
   parameter int unsigned MAX_DIM        = 1024,
   parameter int unsigned SAMPLE_BITS    = 16,
   parameter int unsigned PHASE_BITS     = 16,
   parameter int unsigned COS_TABLE_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [s2dww_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [s2dww_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  s2dww_pkg::ctrl_cmd_type                cmd,
   output logic signed [SAMPLE_BITS-1:0]          rsp_weighted_sample,
   output logic                                   rsp_window_done
);

   import s2dww_pkg::*;

   localparam int unsigned POS_BITS = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned CW = ($clog2(MAX_DIM + 1) > COUNT_BITS) ?
                                $clog2(MAX_DIM + 1) : COUNT_BITS;
   localparam int unsigned QSH  = PHASE_BITS - 2;
   localparam int unsigned CTB  = COS_TABLE_BITS;
   localparam int unsigned PW   = SAMPLE_BITS + 33;
   localparam logic [CTB:0]  QUARTER  = (CTB + 1)'(1) << CTB;
   localparam logic [PW-1:0] RND_HALF = PW'(1) << 29;

   // Configuration registers
   logic [COUNT_BITS-1:0] row_count_ff, col_count_ff;
   logic [STEP_BITS-1:0]  row_step_ff, col_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= RST_ROW_COUNT;
         col_count_ff <= RST_COLUMN_COUNT;
         row_step_ff  <= RST_ROW_STEP;
         col_step_ff  <= RST_COLUMN_STEP;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_COUNT:         row_count_ff <= csr_data[COUNT_BITS-1:0];
            CSR_COLUMN_COUNT:      col_count_ff <= csr_data[COUNT_BITS-1:0];
            CSR_ROW_PHASE_STEP:    row_step_ff  <= csr_data[STEP_BITS-1:0];
            CSR_COLUMN_PHASE_STEP: col_step_ff  <= csr_data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Phase selection and quadrant folding into a ROM address
   logic [PHASE_BITS-1:0] row_phase_ff, row_phase_in;
   logic [PHASE_BITS-1:0] col_phase_ff, col_phase_in;
   logic [PHASE_BITS-1:0] phase_sel;
   logic [1:0]            quad;
   logic [QSH-1:0]        frac;
   logic [CTB-1:0]        tbl_idx;
   logic [CTB:0]          rom_addr;
   logic                  neg_ff;
   logic [15:0]           rom_data;

   assign phase_sel = cmd.rom_col ? col_phase_ff : row_phase_ff;
   assign quad      = phase_sel[PHASE_BITS-1 -: 2];
   assign frac      = phase_sel[QSH-1:0];

   generate
      if (QSH >= CTB) begin : g_idx_trunc
         assign tbl_idx = frac[QSH-1 -: CTB];
      end else begin : g_idx_fill
         assign tbl_idx = {frac, {(CTB - QSH){1'b0}}};
      end
   endgenerate

   assign rom_addr = quad[0] ? (QUARTER - {1'b0, tbl_idx}) : {1'b0, tbl_idx};

   s2dww_cos_rom #(
      .COS_TABLE_BITS(COS_TABLE_BITS)
   ) u_cos_rom (
      .clock  (clock),
      .rd_en  (cmd.rom_rd),
      .rd_addr(rom_addr),
      .rd_data(rom_data)
   );

   // Second and third quadrants carry a negative cosine
   always_ff @(posedge clock) begin
      if (cmd.rom_rd) begin
         neg_ff <= quad[1] ^ quad[0];
      end
   end

   // Q1.15 weight from the signed cosine
   logic signed [16:0] cos_s;
   logic signed [31:0] beta_c;
   logic signed [31:0] w_sum;
   logic [15:0]        weight;

   assign cos_s  = neg_ff ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
   assign beta_c = 32'(cos_s) * BETA_Q15;
   assign w_sum  = WEIGHT_BIAS - beta_c;
   assign weight = w_sum[30:15];

   // Operand and product registers
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [15:0]                   wr_ff, wc_ff;
   logic [31:0]                   ww_ff;
   logic signed [PW-1:0]          prod_ff;
   logic [PW-1:0]                 rnd_sum;

   always_ff @(posedge clock) begin
      if (cmd.sample_ld) begin
         sample_ff <= req_sample;
      end
      if (cmd.wr_ld) begin
         wr_ff <= weight;
      end
      if (cmd.wc_ld) begin
         wc_ff <= weight;
      end
      if (cmd.ww_ld) begin
         ww_ff <= wr_ff * wc_ff;
      end
      if (cmd.prod_ld) begin
         prod_ff <= PW'(sample_ff) * PW'($signed({1'b0, ww_ff}));
      end
   end

   // Round half up and drop the thirty fraction bits
   assign rnd_sum = prod_ff + RND_HALF;

   // Clamped counts and the last index of each dimension
   logic [CW-1:0] row_cnt_ext, col_cnt_ext;
   logic [CW-1:0] row_last, col_last;

   always_comb begin
      row_cnt_ext = CW'(row_count_ff);
      col_cnt_ext = CW'(col_count_ff);
      if (row_cnt_ext < CW'(2)) begin
         row_cnt_ext = CW'(2);
      end else if (row_cnt_ext > CW'(MAX_DIM)) begin
         row_cnt_ext = CW'(MAX_DIM);
      end
      if (col_cnt_ext < CW'(2)) begin
         col_cnt_ext = CW'(2);
      end else if (col_cnt_ext > CW'(MAX_DIM)) begin
         col_cnt_ext = CW'(MAX_DIM);
      end
      row_last = row_cnt_ext - CW'(1);
      col_last = col_cnt_ext - CW'(1);
   end

   // Raster position and phase stepping
   logic [POS_BITS-1:0] row_pos_ff, row_pos_in;
   logic [POS_BITS-1:0] col_pos_ff, col_pos_in;
   logic                done_in;

   always_comb begin
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      row_phase_in = row_phase_ff;
      col_phase_in = col_phase_ff;
      done_in      = 1'b0;
      if (CW'(col_pos_ff) >= col_last) begin
         col_pos_in   = '0;
         col_phase_in = '0;
         if (CW'(row_pos_ff) >= row_last) begin
            row_pos_in   = '0;
            row_phase_in = '0;
            done_in      = 1'b1;
         end else begin
            row_pos_in   = row_pos_ff + POS_BITS'(1);
            row_phase_in = row_phase_ff + PHASE_BITS'(row_step_ff);
         end
      end else begin
         col_pos_in   = col_pos_ff + POS_BITS'(1);
         col_phase_in = col_phase_ff + PHASE_BITS'(col_step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
      end else if (cmd.commit) begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
      end
   end

   // Output word register
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_sample_ff <= $signed(rnd_sum[30 +: SAMPLE_BITS]);
         out_done_ff   <= done_in;
      end
   end

   assign rsp_weighted_sample = out_sample_ff;
   assign rsp_window_done     = out_done_ff;

endmodule

// File: sv/separable_2d_window_weighting.sv
`timescale 1ns / 1ps
// Top level of the separable 2-D Hamming window weighting block.
// Depends on s2dww_pkg, s2dww_ctrl and s2dww_dp.

// Weights a raster-order stream of window samples by wr(row)*wc(column),
// with w(k) = 25/46 - 21/46*cos(2*pi*k/(N-1)) in Q1.15, and rounds the
// product back to the sample width; the last sample of each window carries
// window_done. After acceptance a word steps through the row ROM read, the
// row weight, the column ROM read, the column weight, the weight product and
// the sample product before its result is loaded, and the input side takes
// no new word until then, as the single-port cosine ROM is read once for
// the row weight and once for the column weight, each read followed by a
// weight cycle, then the two multiplies run in turn. A new word is accepted
// while the previous result still waits to be taken, but its own result
// waits in the last cycle until that earlier result has gone. Write the row
// and column counts and the phase steps, round(65536/(N-1)), only while no
// word is in flight; a write does not reset the raster position.

module separable_2d_window_weighting #(
   parameter int unsigned MAX_DIM        = s2dww_pkg::DEF_MAX_DIM,
   parameter int unsigned SAMPLE_BITS    = s2dww_pkg::DEF_SAMPLE_BITS,
   parameter int unsigned PHASE_BITS     = s2dww_pkg::DEF_PHASE_BITS,
   parameter int unsigned COS_TABLE_BITS = s2dww_pkg::DEF_COS_TABLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [s2dww_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [s2dww_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_weighted_sample,
   output logic                                 rsp_window_done
);

   import s2dww_pkg::*;

   ctrl_cmd_type cmd;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   s2dww_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   s2dww_dp #(
      .MAX_DIM       (MAX_DIM),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .PHASE_BITS    (PHASE_BITS),
      .COS_TABLE_BITS(COS_TABLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_sample         (req_sample),
      .cmd                (cmd),
      .rsp_weighted_sample(rsp_weighted_sample),
      .rsp_window_done    (rsp_window_done)
   );

`ifndef ASSERT_OFF
   // Once a word is taken the input side holds off until it is finished.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted again straight after an accepted word");

   // With the output empty at acceptance, a result appears without waiting to commit.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |-> ##8 rsp_valid)
      else $error("result did not appear on time");

   // A result only appears at the end of a word's processing.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no word in flight");
`endif

endmodule
